>>> rtl/affine_transform_accumulator_macros.svh
// Assertion helpers shared by the RTL of the affine transform accumulator.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define ATA_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ATA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ATA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ata_pkg.sv
`timescale 1ns / 1ps

package ata_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    OP_COMPOSE  = 2'd0,
    OP_XFORM    = 2'd1,
    OP_INVERT   = 2'd2,
    OP_IDENTITY = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_IDENT       = 3'd0,
    KIND_TRANS       = 3'd1,
    KIND_SCALE       = 3'd2,
    KIND_SCALE_TRANS = 3'd3,
    KIND_GENERAL     = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_A, SRC_B, SRC_C, SRC_D, SRC_TX, SRC_TY,
    SRC_M0, SRC_M1, SRC_M2, SRC_M3, SRC_M4, SRC_M5, SRC_PX, SRC_PY,
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5,
    SRC_DET, SRC_R, SRC_U, SRC_RX, SRC_RY
  } src_t;

  typedef enum logic [3:0] {
    DST_T0, DST_T1, DST_T2, DST_T3, DST_T4, DST_T5,
    DST_DET, DST_R, DST_U, DST_RX, DST_RY
  } dst_t;

  typedef enum logic [1:0] {
    FN_MUL, FN_PASS, FN_RECIP
  } fn_t;

  // One step of the sequencer: product = fn(a, b), then dst = c + product, or c - product when neg_p is set.
  typedef struct packed {
    src_t src_a;
    logic neg_a;
    src_t src_b;
    fn_t  fn;
    src_t src_c;
    logic neg_p;
    dst_t dst;
    logic chk;
    logic last;
  } uop_t;

  localparam int PC_W = 6;

  localparam logic [PC_W-1:0] PC_COMPOSE   = 6'd0;
  localparam logic [PC_W-1:0] PC_XFORM     = 6'd14;
  localparam logic [PC_W-1:0] PC_INV_TRANS = 6'd18;
  localparam logic [PC_W-1:0] PC_INV_ST    = 6'd20;
  localparam logic [PC_W-1:0] PC_INV_S     = 6'd25;
  localparam logic [PC_W-1:0] PC_INV_GEN   = 6'd28;

  localparam logic N = 1'b0;
  localparam logic Y = 1'b1;

  function automatic uop_t mk(input src_t a, input logic na, input src_t b, input fn_t f,
                              input src_t c, input logic np, input dst_t d,
                              input logic chk, input logic last);
    uop_t u;
    u.src_a = a;
    u.neg_a = na;
    u.src_b = b;
    u.fn    = f;
    u.src_c = c;
    u.neg_p = np;
    u.dst   = d;
    u.chk   = chk;
    u.last  = last;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // compose: new = old * incoming
      6'd0:  u = mk(SRC_A,  N, SRC_M0, FN_MUL,  SRC_ZERO, N, DST_T0, N, N);
      6'd1:  u = mk(SRC_B,  N, SRC_M2, FN_MUL,  SRC_T0,   N, DST_T0, N, N);
      6'd2:  u = mk(SRC_A,  N, SRC_M1, FN_MUL,  SRC_ZERO, N, DST_T1, N, N);
      6'd3:  u = mk(SRC_B,  N, SRC_M3, FN_MUL,  SRC_T1,   N, DST_T1, N, N);
      6'd4:  u = mk(SRC_C,  N, SRC_M0, FN_MUL,  SRC_ZERO, N, DST_T2, N, N);
      6'd5:  u = mk(SRC_D,  N, SRC_M2, FN_MUL,  SRC_T2,   N, DST_T2, N, N);
      6'd6:  u = mk(SRC_C,  N, SRC_M1, FN_MUL,  SRC_ZERO, N, DST_T3, N, N);
      6'd7:  u = mk(SRC_D,  N, SRC_M3, FN_MUL,  SRC_T3,   N, DST_T3, N, N);
      6'd8:  u = mk(SRC_TX, N, SRC_M0, FN_MUL,  SRC_ZERO, N, DST_T4, N, N);
      6'd9:  u = mk(SRC_TY, N, SRC_M2, FN_MUL,  SRC_T4,   N, DST_T4, N, N);
      6'd10: u = mk(SRC_M4, N, SRC_M4, FN_PASS, SRC_T4,   N, DST_T4, N, N);
      6'd11: u = mk(SRC_TX, N, SRC_M1, FN_MUL,  SRC_ZERO, N, DST_T5, N, N);
      6'd12: u = mk(SRC_TY, N, SRC_M3, FN_MUL,  SRC_T5,   N, DST_T5, N, N);
      6'd13: u = mk(SRC_M5, N, SRC_M5, FN_PASS, SRC_T5,   N, DST_T5, N, Y);
      // transform point
      6'd14: u = mk(SRC_PY, N, SRC_C,  FN_MUL,  SRC_TX,   N, DST_RX, N, N);
      6'd15: u = mk(SRC_PX, N, SRC_A,  FN_MUL,  SRC_RX,   N, DST_RX, N, N);
      6'd16: u = mk(SRC_PX, N, SRC_B,  FN_MUL,  SRC_TY,   N, DST_RY, N, N);
      6'd17: u = mk(SRC_PY, N, SRC_D,  FN_MUL,  SRC_RY,   N, DST_RY, N, Y);
      // invert translate
      6'd18: u = mk(SRC_TX, Y, SRC_TX, FN_PASS, SRC_ZERO, N, DST_T4, N, N);
      6'd19: u = mk(SRC_TY, Y, SRC_TY, FN_PASS, SRC_ZERO, N, DST_T5, N, Y);
      // invert scale plus translate
      6'd20: u = mk(SRC_A,  N, SRC_D,  FN_MUL,  SRC_ZERO, N, DST_DET, Y, N);
      6'd21: u = mk(SRC_A,  N, SRC_A,  FN_RECIP, SRC_ZERO, N, DST_T0, N, N);
      6'd22: u = mk(SRC_D,  N, SRC_D,  FN_RECIP, SRC_ZERO, N, DST_T3, N, N);
      6'd23: u = mk(SRC_TX, Y, SRC_T0, FN_MUL,  SRC_ZERO, N, DST_T4, N, N);
      6'd24: u = mk(SRC_TY, Y, SRC_T3, FN_MUL,  SRC_ZERO, N, DST_T5, N, Y);
      // invert scale
      6'd25: u = mk(SRC_A,  N, SRC_D,  FN_MUL,  SRC_ZERO, N, DST_DET, Y, N);
      6'd26: u = mk(SRC_A,  N, SRC_A,  FN_RECIP, SRC_ZERO, N, DST_T0, N, N);
      6'd27: u = mk(SRC_D,  N, SRC_D,  FN_RECIP, SRC_ZERO, N, DST_T3, N, Y);
      // invert general
      6'd28: u = mk(SRC_A,  N, SRC_D,  FN_MUL,  SRC_ZERO, N, DST_DET, N, N);
      6'd29: u = mk(SRC_B,  N, SRC_C,  FN_MUL,  SRC_DET,  Y, DST_DET, Y, N);
      6'd30: u = mk(SRC_DET, N, SRC_DET, FN_RECIP, SRC_ZERO, N, DST_R, N, N);
      6'd31: u = mk(SRC_D,  N, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T0, N, N);
      6'd32: u = mk(SRC_B,  Y, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T1, N, N);
      6'd33: u = mk(SRC_C,  Y, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T2, N, N);
      6'd34: u = mk(SRC_A,  N, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T3, N, N);
      6'd35: u = mk(SRC_C,  N, SRC_TY, FN_MUL,  SRC_ZERO, N, DST_U,  N, N);
      6'd36: u = mk(SRC_D,  N, SRC_TX, FN_MUL,  SRC_U,    Y, DST_U,  N, N);
      6'd37: u = mk(SRC_U,  N, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T4, N, N);
      6'd38: u = mk(SRC_B,  N, SRC_TX, FN_MUL,  SRC_ZERO, N, DST_U,  N, N);
      6'd39: u = mk(SRC_A,  N, SRC_TY, FN_MUL,  SRC_U,    Y, DST_U,  N, N);
      6'd40: u = mk(SRC_U,  N, SRC_R,  FN_MUL,  SRC_ZERO, N, DST_T5, N, Y);
      default: u = mk(SRC_ZERO, N, SRC_ZERO, FN_PASS, SRC_ZERO, N, DST_U, N, Y);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/affine_transform_accumulator.sv
`timescale 1ns / 1ps
`include "affine_transform_accumulator_macros.svh"

// Affine transform accumulator. Holds a running 2D affine matrix (a b / c d / tx ty,
// row-vector convention, signed fixed point with FRAC_BITS fraction bits) and its
// class, and takes one item per request on the slave stream: compose with an
// incoming matrix, transform a point, invert, or restore the identity. Every item
// returns one result item carrying the matrix after the step, its class, the
// transformed point (zero for other operations) and a flag for an invert that met
// a zero determinant (the matrix is then kept). All products, sums and negations
// saturate. The work runs on one shared multiplier and a bit-serial reciprocal
// divider under a small microcode sequencer: each microcode step multiplies, then
// accumulates, and a reciprocal step runs the divider between the two. Identity
// and invert of the identity skip the sequencer and go straight to the final
// state. An invert that meets a zero determinant stops early, and a previous
// result still waiting unaccepted holds the block in its final state. s_tready is
// high only while the sequencer is idle; a finished result waits in the output
// register without holding up the next item's acceptance.
module affine_transform_accumulator #(
  parameter int COEF_WIDTH = ata_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = ata_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // coef_a, coef_b, coef_c, coef_d, offset_x, offset_y, point_x, point_y
  input  logic [8*COEF_WIDTH-1:0] s_tdata,
  // operation
  input  logic [1:0]              s_tuser,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // cur_a, cur_b, cur_c, cur_d, cur_tx, cur_ty, result_x, result_y
  output logic [8*COEF_WIDTH-1:0] m_tdata,
  // matrix_kind [2:0], not_invertible [3]
  output logic [3:0]              m_tuser
);

  localparam int W    = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int QW   = 2 * F + 1;
  localparam int CW   = ((QW > W) ? QW : W) + 2;
  localparam int CNTW = $clog2(QW + 1);
  localparam int PCW  = ata_pkg::PC_W;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = (F >= W - 1) ? WMAX : (W'(1) << F);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_ACC, S_FIN
  } state_t;

  state_t state;

  // held matrix and class
  logic signed [W-1:0] mat_a, mat_b, mat_c, mat_d, mat_tx, mat_ty;
  ata_pkg::kind_t      kind_reg;

  // item operands and working registers
  ata_pkg::op_t        op;
  logic signed [W-1:0] m0, m1, m2, m3, m4, m5, px, py;
  logic signed [W-1:0] t0, t1, t2, t3, t4, t5;
  logic signed [W-1:0] det, rcp, u, rx, ry, prod;
  logic                fail;
  logic [ata_pkg::PC_W-1:0] pc;

  // reciprocal divider
  logic [W:0]      div_rem;
  logic [W-1:0]    div_m;
  logic [QW-1:0]   div_q;
  logic [CNTW-1:0] div_cnt;
  logic            div_neg;

  ata_pkg::uop_t   uop;
  logic signed [W-1:0] opa_raw, opa, opb, opc, prod_next, acc_next;
  logic [W-1:0]    opa_mag;
  logic [W:0]      rem_sh;
  ata_pkg::kind_t  kind_next;
  ata_pkg::kind_t  kind_cls;

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] v);
    if (v == WMIN) return WMAX;
    return -v;
  endfunction

  // floor(x*y / 2^F), saturated
  function automatic logic signed [W-1:0] sat_mul(input logic signed [W-1:0] x,
                                                   input logic signed [W-1:0] y);
    logic signed [2*W-1:0] p;
    logic signed [2*W-1:0] q;
    p = $signed({{W{x[W-1]}}, x}) * $signed({{W{y[W-1]}}, y});
    q = p >>> F;
    if (q[2*W-1:W-1] != {(W+1){1'b0}} && q[2*W-1:W-1] != {(W+1){1'b1}})
      return q[2*W-1] ? WMIN : WMAX;
    return q[W-1:0];
  endfunction

  // saturate a quotient magnitude with its sign
  function automatic logic signed [W-1:0] sat_quot(input logic neg, input logic [QW-1:0] q);
    logic [CW-1:0] qe;
    logic [CW-1:0] lim;
    qe  = CW'(q);
    lim = CW'({1'b0, WMAX});
    if (!neg) return (qe > lim) ? WMAX : qe[W-1:0];
    if (qe > lim + CW'(1)) return WMIN;
    return -$signed(qe[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] pick(input ata_pkg::src_t s);
    logic signed [W-1:0] v;
    case (s)
      ata_pkg::SRC_A:   v = mat_a;
      ata_pkg::SRC_B:   v = mat_b;
      ata_pkg::SRC_C:   v = mat_c;
      ata_pkg::SRC_D:   v = mat_d;
      ata_pkg::SRC_TX:  v = mat_tx;
      ata_pkg::SRC_TY:  v = mat_ty;
      ata_pkg::SRC_M0:  v = m0;
      ata_pkg::SRC_M1:  v = m1;
      ata_pkg::SRC_M2:  v = m2;
      ata_pkg::SRC_M3:  v = m3;
      ata_pkg::SRC_M4:  v = m4;
      ata_pkg::SRC_M5:  v = m5;
      ata_pkg::SRC_PX:  v = px;
      ata_pkg::SRC_PY:  v = py;
      ata_pkg::SRC_T0:  v = t0;
      ata_pkg::SRC_T1:  v = t1;
      ata_pkg::SRC_T2:  v = t2;
      ata_pkg::SRC_T3:  v = t3;
      ata_pkg::SRC_T4:  v = t4;
      ata_pkg::SRC_T5:  v = t5;
      ata_pkg::SRC_DET: v = det;
      ata_pkg::SRC_R:   v = rcp;
      ata_pkg::SRC_U:   v = u;
      ata_pkg::SRC_RX:  v = rx;
      ata_pkg::SRC_RY:  v = ry;
      default:          v = '0;
    endcase
    return v;
  endfunction

  assign s_tready = (state == S_IDLE);

  always_comb begin
    uop       = ata_pkg::ucode(pc);
    opa_raw   = pick(uop.src_a);
    opa       = uop.neg_a ? sat_neg(opa_raw) : opa_raw;
    opb       = pick(uop.src_b);
    opc       = pick(uop.src_c);
    opa_mag   = opa[W-1] ? W'(-opa) : W'(opa);
    prod_next = (uop.fn == ata_pkg::FN_PASS) ? opa : sat_mul(opa, opb);
    acc_next  = sat_add(opc, uop.neg_p ? sat_neg(prod) : prod);
    // the dividend is a single one at bit 2F: feed it on the first step only
    rem_sh    = {div_rem[W-1:0], (div_cnt == CNTW'(QW))};
  end

  // class of the composed matrix, and the class each operation leaves behind
  always_comb begin
    if (t1 != '0 || t2 != '0) begin
      kind_cls = ata_pkg::KIND_GENERAL;
    end else begin
      case ({(t0 != ONE || t3 != ONE), (t4 != '0 || t5 != '0)})
        2'b00:   kind_cls = ata_pkg::KIND_IDENT;
        2'b01:   kind_cls = ata_pkg::KIND_TRANS;
        2'b10:   kind_cls = ata_pkg::KIND_SCALE;
        default: kind_cls = ata_pkg::KIND_SCALE_TRANS;
      endcase
    end
    case (op)
      ata_pkg::OP_COMPOSE:  kind_next = kind_cls;
      ata_pkg::OP_IDENTITY: kind_next = ata_pkg::KIND_IDENT;
      default:              kind_next = kind_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mat_a    <= ONE;
      mat_b    <= '0;
      mat_c    <= '0;
      mat_d    <= ONE;
      mat_tx   <= '0;
      mat_ty   <= '0;
      kind_reg <= ata_pkg::KIND_IDENT;
      m_tvalid <= 1'b0;
      fail     <= 1'b0;
      pc       <= '0;
      div_cnt  <= '0;
    end else begin
      // drop the result once taken; the final state reloads it itself
      if (m_tready && state != S_FIN) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op   <= ata_pkg::op_t'(s_tuser);
            m0   <= s_tdata[0*W +: W];
            m1   <= s_tdata[1*W +: W];
            m2   <= s_tdata[2*W +: W];
            m3   <= s_tdata[3*W +: W];
            m4   <= s_tdata[4*W +: W];
            m5   <= s_tdata[5*W +: W];
            px   <= s_tdata[6*W +: W];
            py   <= s_tdata[7*W +: W];
            rx   <= '0;
            ry   <= '0;
            fail <= 1'b0;
            // working copy starts from the held matrix, or identity
            if (ata_pkg::op_t'(s_tuser) == ata_pkg::OP_IDENTITY) begin
              t0 <= ONE;
              t1 <= '0;
              t2 <= '0;
              t3 <= ONE;
              t4 <= '0;
              t5 <= '0;
            end else begin
              t0 <= mat_a;
              t1 <= mat_b;
              t2 <= mat_c;
              t3 <= mat_d;
              t4 <= mat_tx;
              t5 <= mat_ty;
            end
            case (ata_pkg::op_t'(s_tuser))
              ata_pkg::OP_COMPOSE: begin
                pc    <= ata_pkg::PC_COMPOSE;
                state <= S_MUL;
              end
              ata_pkg::OP_XFORM: begin
                pc    <= ata_pkg::PC_XFORM;
                state <= S_MUL;
              end
              ata_pkg::OP_INVERT: begin
                case (kind_reg)
                  ata_pkg::KIND_IDENT: begin
                    state <= S_FIN;
                  end
                  ata_pkg::KIND_TRANS: begin
                    pc    <= ata_pkg::PC_INV_TRANS;
                    state <= S_MUL;
                  end
                  ata_pkg::KIND_SCALE: begin
                    pc    <= ata_pkg::PC_INV_S;
                    state <= S_MUL;
                  end
                  ata_pkg::KIND_SCALE_TRANS: begin
                    pc    <= ata_pkg::PC_INV_ST;
                    state <= S_MUL;
                  end
                  default: begin
                    pc    <= ata_pkg::PC_INV_GEN;
                    state <= S_MUL;
                  end
                endcase
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end

        S_MUL: begin
          if (uop.fn == ata_pkg::FN_RECIP) begin
            if (opa_mag == '0) begin
              prod  <= WMAX;
              state <= S_ACC;
            end else begin
              div_m   <= opa_mag;
              div_neg <= opa[W-1];
              div_rem <= '0;
              div_q   <= '0;
              div_cnt <= CNTW'(QW);
              state   <= S_DIV;
            end
          end else begin
            prod  <= prod_next;
            state <= S_ACC;
          end
        end

        S_DIV: begin
          // one quotient bit a cycle, restoring
          if (div_cnt == '0) begin
            prod  <= sat_quot(div_neg, div_q);
            state <= S_ACC;
          end else begin
            if (rem_sh >= {1'b0, div_m}) begin
              div_rem <= rem_sh - {1'b0, div_m};
              div_q   <= {div_q[QW-2:0], 1'b1};
            end else begin
              div_rem <= rem_sh;
              div_q   <= {div_q[QW-2:0], 1'b0};
            end
            div_cnt <= div_cnt - CNTW'(1);
          end
        end

        S_ACC: begin
          case (uop.dst)
            ata_pkg::DST_T0:  t0  <= acc_next;
            ata_pkg::DST_T1:  t1  <= acc_next;
            ata_pkg::DST_T2:  t2  <= acc_next;
            ata_pkg::DST_T3:  t3  <= acc_next;
            ata_pkg::DST_T4:  t4  <= acc_next;
            ata_pkg::DST_T5:  t5  <= acc_next;
            ata_pkg::DST_DET: det <= acc_next;
            ata_pkg::DST_R:   rcp <= acc_next;
            ata_pkg::DST_U:   u   <= acc_next;
            ata_pkg::DST_RX:  rx  <= acc_next;
            ata_pkg::DST_RY:  ry  <= acc_next;
            default:          u   <= acc_next;
          endcase
          // zero determinant: stop before the working copy is touched
          if (uop.chk && acc_next == '0) begin
            fail  <= 1'b1;
            state <= S_FIN;
          end else if (uop.last) begin
            state <= S_FIN;
          end else begin
            pc    <= pc + PCW'(1);
            state <= S_MUL;
          end
        end

        S_FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            mat_a    <= t0;
            mat_b    <= t1;
            mat_c    <= t2;
            mat_d    <= t3;
            mat_tx   <= t4;
            mat_ty   <= t5;
            kind_reg <= kind_next;
            m_tdata  <= {ry, rx, t5, t4, t3, t2, t1, t0};
            m_tuser  <= {fail, kind_next};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ATA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `ATA_ASSERT_SAME(a_acc_entry, state == S_ACC, $past(state) == S_MUL || $past(state) == S_DIV, "accumulate without product")
  `ATA_ASSERT_SAME(a_fail_kind, m_tvalid && m_tuser[3], kind_reg == ata_pkg::KIND_SCALE || kind_reg == ata_pkg::KIND_SCALE_TRANS || kind_reg == ata_pkg::KIND_GENERAL, "invert failed on a class with unit determinant")
  `ATA_ASSERT_SAME(a_ident_matrix, kind_reg == ata_pkg::KIND_IDENT, mat_a == ONE && mat_d == ONE && mat_b == '0 && mat_c == '0 && mat_tx == '0 && mat_ty == '0, "identity class on a non-identity matrix")

endmodule

>>> tb/tb_affine_transform_accumulator.sv
`timescale 1ns / 1ps

// Self-checking bench for the affine transform accumulator.
module tb_affine_transform_accumulator;

  localparam int ONE      = 32'sh0001_0000;
  localparam int MAXV     = 32'sh7fff_ffff;
  localparam int MINV     = 32'sh8000_0000;
  localparam int LIMIT    = 1000000;
  localparam int N_RANDOM = 940;

  // One result item as the block should produce it.
  typedef struct {
    logic [31:0] m [6];
    logic [2:0]  kind;
    logic [31:0] rx;
    logic [31:0] ry;
    logic        bad_det;
  } affine_result_t;

  // Running copy of the matrix and the queue of results still to arrive.
  class affine_scoreboard;
    longint mat [6];
    ata_pkg::kind_t kind;
    affine_result_t pending [$];
    int     errors;

    function new();
      errors = 0;
      set_identity();
    endfunction

    function void set_identity();
      mat[0] = ONE; mat[1] = 0; mat[2] = 0; mat[3] = ONE; mat[4] = 0; mat[5] = 0;
      kind = ata_pkg::KIND_IDENT;
    endfunction

    // Clamp to the 32-bit signed range.
    function longint sat(longint v);
      if (v > longint'(MAXV)) return longint'(MAXV);
      if (v < longint'(MINV)) return longint'(MINV);
      return v;
    endfunction

    function longint mul(longint x, longint y);
      longint p;
      p = x * y;
      return sat(p >>> 16);
    endfunction

    function longint add(longint x, longint y);
      return sat(x + y);
    endfunction

    function longint neg(longint v);
      return sat(-v);
    endfunction

    // 2^32 / v truncated toward zero; zero saturates positive.
    function longint recip(longint v);
      longint m;
      longint q;
      if (v == 0) return longint'(MAXV);
      m = (v < 0) ? -v : v;
      q = (64'sd1 <<< 32) / m;
      return sat((v < 0) ? -q : q);
    endfunction

    function void reclassify();
      if (mat[1] != 0 || mat[2] != 0) begin
        kind = ata_pkg::KIND_GENERAL;
      end else begin
        kind = ata_pkg::KIND_IDENT;
        if (mat[0] != ONE || mat[3] != ONE) kind = ata_pkg::KIND_SCALE;
        if (mat[4] != 0 || mat[5] != 0) kind = ata_pkg::kind_t'(kind | 3'd1);
      end
    endfunction

    // Returns 1 when the determinant is zero and the matrix is kept.
    function bit invert();
      longint det;
      longint r;
      longint nm [6];
      if (kind <= ata_pkg::KIND_TRANS) det = ONE;
      else if (kind <= ata_pkg::KIND_SCALE_TRANS) det = mul(mat[0], mat[3]);
      else det = add(mul(mat[0], mat[3]), neg(mul(mat[1], mat[2])));
      if (det == 0) return 1'b1;
      case (kind)
        ata_pkg::KIND_IDENT: ;
        ata_pkg::KIND_TRANS: begin
          mat[4] = neg(mat[4]);
          mat[5] = neg(mat[5]);
        end
        ata_pkg::KIND_SCALE, ata_pkg::KIND_SCALE_TRANS: begin
          mat[0] = recip(mat[0]);
          mat[3] = recip(mat[3]);
          if (kind == ata_pkg::KIND_SCALE_TRANS) begin
            mat[4] = mul(neg(mat[4]), mat[0]);
            mat[5] = mul(neg(mat[5]), mat[3]);
          end
        end
        default: begin
          // adjugate over the determinant, all from the old coefficients
          r = recip(det);
          nm[0] = mul(mat[3], r);
          nm[1] = mul(neg(mat[1]), r);
          nm[2] = mul(neg(mat[2]), r);
          nm[3] = mul(mat[0], r);
          nm[4] = mul(add(mul(mat[2], mat[5]), neg(mul(mat[3], mat[4]))), r);
          nm[5] = mul(add(mul(mat[1], mat[4]), neg(mul(mat[0], mat[5]))), r);
          mat = nm;
          kind = ata_pkg::KIND_GENERAL;
        end
      endcase
      return 1'b0;
    endfunction

    // Note an accepted input item and queue its expected result.
    function void note_item(ata_pkg::op_t op, int in_m [6], int px, int py);
      longint m [6];
      longint nm [6];
      affine_result_t res;
      foreach (m[i]) m[i] = longint'(in_m[i]);
      res.rx = '0;
      res.ry = '0;
      res.bad_det = 1'b0;
      case (op)
        ata_pkg::OP_COMPOSE: begin
          nm[0] = add(mul(mat[0], m[0]), mul(mat[1], m[2]));
          nm[1] = add(mul(mat[0], m[1]), mul(mat[1], m[3]));
          nm[2] = add(mul(mat[2], m[0]), mul(mat[3], m[2]));
          nm[3] = add(mul(mat[2], m[1]), mul(mat[3], m[3]));
          nm[4] = add(add(mul(mat[4], m[0]), mul(mat[5], m[2])), m[4]);
          nm[5] = add(add(mul(mat[4], m[1]), mul(mat[5], m[3])), m[5]);
          mat = nm;
          reclassify();
        end
        ata_pkg::OP_XFORM: begin
          res.rx = 32'(add(mul(longint'(px), mat[0]),
                           add(mul(longint'(py), mat[2]), mat[4])));
          res.ry = 32'(add(mul(longint'(py), mat[3]),
                           add(mul(longint'(px), mat[1]), mat[5])));
        end
        ata_pkg::OP_INVERT: res.bad_det = invert();
        default: set_identity();
      endcase
      foreach (res.m[i]) res.m[i] = mat[i][31:0];
      res.kind = kind;
      pending.push_back(res);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %h, actual %h", field, want, got);
        errors++;
      end
    endfunction

    // Check one result item against the oldest expectation.
    function void check_result(logic [255:0] data, logic [3:0] user);
      affine_result_t e;
      if (pending.size() == 0) begin
        $error("result: expected none, actual %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("cur_a", e.m[0], data[31:0]);
      cmp("cur_b", e.m[1], data[63:32]);
      cmp("cur_c", e.m[2], data[95:64]);
      cmp("cur_d", e.m[3], data[127:96]);
      cmp("cur_tx", e.m[4], data[159:128]);
      cmp("cur_ty", e.m[5], data[191:160]);
      cmp("result_x", e.rx, data[223:192]);
      cmp("result_y", e.ry, data[255:224]);
      cmp("matrix_kind", 32'(e.kind), 32'(user[2:0]));
      cmp("not_invertible", 32'(e.bad_det), 32'(user[3]));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [255:0] m_tdata;
  logic [3:0]   m_tuser;

  affine_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int cycles = 0;

  always #4 clk = ~clk;

  affine_transform_accumulator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Abort the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("affine_transform_accumulator regression: fail");
      $finish;
    end
  end

  // Receiver: check every accepted result, then pick the next ready value.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Offer one item, idling first at random; note it once accepted.
  task automatic send_item(ata_pkg::op_t op, int a, int b, int c, int d, int tx, int ty,
                           int px, int py);
    int m [6];
    m = '{a, b, c, d, tx, ty};
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {py, px, ty, tx, d, c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(op, m, px, py);
  endtask

  // Coefficient near the useful range, with zero and one common; any value when wide.
  function automatic int pick_coef(bit diag, bit wide);
    int sel;
    sel = $urandom_range(9);
    if (wide) return int'($urandom());
    if (sel < 4) return diag ? ONE : 0;
    if (sel == 4) return diag ? -ONE : ONE;
    return int'($urandom_range(32'h0006_0000)) - 32'sh0003_0000;
  endfunction

  task automatic send_random();
    int sel;
    bit wide;
    bit gen;
    sel  = $urandom_range(99);
    wide = ($urandom_range(4) == 0);
    gen  = ($urandom_range(2) == 0);
    if (sel < 45)
      send_item(ata_pkg::OP_COMPOSE, pick_coef(1, wide), gen ? pick_coef(0, wide) : 0,
                gen ? pick_coef(0, wide) : 0, pick_coef(1, wide),
                pick_coef(0, wide), pick_coef(0, wide), int'($urandom()), int'($urandom()));
    else if (sel < 70)
      send_item(ata_pkg::OP_XFORM, int'($urandom()), int'($urandom()), int'($urandom()),
                int'($urandom()), int'($urandom()), int'($urandom()),
                pick_coef(0, wide), pick_coef(0, wide));
    else if (sel < 90)
      send_item(ata_pkg::OP_INVERT, int'($urandom()), int'($urandom()), int'($urandom()),
                int'($urandom()), int'($urandom()), int'($urandom()),
                int'($urandom()), int'($urandom()));
    else
      send_item(ata_pkg::OP_IDENTITY, int'($urandom()), int'($urandom()), int'($urandom()),
                int'($urandom()), int'($urandom()), int'($urandom()),
                int'($urandom()), int'($urandom()));
  endtask

  initial begin
    int idle_plan [4] = '{0, 74, 0, 30};
    int stall_plan [4] = '{0, 0, 74, 30};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: transform through the identity, at the field extremes too.
    send_item(ata_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0, ONE, -ONE);
    send_item(ata_pkg::OP_XFORM, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // pure translate, then undo it
    send_item(ata_pkg::OP_COMPOSE, ONE, 0, 0, ONE, 5 * ONE, -3, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // scale plus translate, then its inverse
    send_item(ata_pkg::OP_COMPOSE, 2 * ONE, 0, 0, ONE / 2, 0, 0, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ata_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0, 3 * ONE, -7 * ONE);
    // pure scale with a negative factor
    send_item(ata_pkg::OP_IDENTITY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ata_pkg::OP_COMPOSE, -3 * ONE, 0, 0, 7 * ONE, 0, 0, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // general matrix and its inverse
    send_item(ata_pkg::OP_COMPOSE, ONE, ONE, -2 * ONE, 3 * ONE, 4 * ONE, -ONE, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ata_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0, ONE, ONE);
    // saturation everywhere
    send_item(ata_pkg::OP_COMPOSE, MAXV, MINV, MINV, MAXV, MAXV, MINV, 0, 0);
    send_item(ata_pkg::OP_XFORM, 0, 0, 0, 0, 0, 0, MINV, MAXV);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // zero scale: determinant zero, matrix kept
    send_item(ata_pkg::OP_IDENTITY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ata_pkg::OP_COMPOSE, 0, 0, 0, 0, ONE, 0, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // singular general matrix
    send_item(ata_pkg::OP_IDENTITY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(ata_pkg::OP_COMPOSE, ONE, ONE, ONE, ONE, 0, 0, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);
    // most negative value through negation
    send_item(ata_pkg::OP_COMPOSE, MINV, 0, 0, ONE, MINV, 0, 0, 0);
    send_item(ata_pkg::OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0);

    // Random part over the idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = idle_plan[ph];
      sink_stall_pct = stall_plan[ph];
      for (int n = 0; n < N_RANDOM / 4; n++) send_random();
    end
    s_tvalid <= 1'b0;

    // Drain, then allow a little settling time.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("affine_transform_accumulator regression: pass");
    end else begin
      $display("affine_transform_accumulator regression: fail");
    end
    $finish;
  end
endmodule
